### rtl/free_extent_block_allocator_defines.svh
// Assertion macros for the free extent block allocator.
// Used by the top level only; expects clk and rst in scope.
`ifndef FREE_EXTENT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FREE_EXTENT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define FEBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define FEBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/feba_pkg.sv
// Shared types and constants for the free extent block allocator.
// No dependencies; used by feba_hdr_store and the top level.
`timescale 1ns / 1ps

package feba_pkg;

  // Block numbers and header fields are 12 bits wide
  localparam int BW  = 12;
  localparam int VBW = 13;

  localparam logic [VBW-1:0] VOLUME_BLOCKS_RESET = 13'd4096;

  // Register byte address bit that selects the register index
  localparam logic REG_VOLUME_BLOCKS = 1'b0;

  localparam logic [1:0] OP_FORMAT = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;

  localparam logic [2:0] ST_OK                = 3'd0;
  localparam logic [2:0] ST_NOT_FORMATTED     = 3'd1;
  localparam logic [2:0] ST_NO_SPACE          = 3'd2;
  localparam logic [2:0] ST_RANGE             = 3'd3;
  localparam logic [2:0] ST_ALREADY_FREE      = 3'd4;
  localparam logic [2:0] ST_ALREADY_FORMATTED = 3'd5;

  // One extent header: length and next listed block
  typedef struct packed {
    logic [BW-1:0] len;
    logic [BW-1:0] nxt;
  } hdr_t;

  // Header store request: one write and one read per cycle
  typedef struct packed {
    logic          we;
    logic [BW-1:0] waddr;
    hdr_t          wdata;
    logic [BW-1:0] raddr;
  } hdr_req_t;

endpackage

### rtl/free_extent_block_allocator.sv
// Free extent block allocator: sorted free list of extents in a header store.
// Format, opcode 3, unformatted, out-of-range and no-space commands end in S_IDLE;
// allocate passes S_AEXE; free walks listed extents in S_FWALK, plus S_FLINK on a relink.
// One header read per cycle sets the walk time. Throughput: one word at a time;
// busy is low again in the done cycle, so the next word can be taken there.
// Reset clears control, counts and flags, sets volume_blocks to 4096; not headers.
`timescale 1ns / 1ps

`include "free_extent_block_allocator_defines.svh"

module free_extent_block_allocator #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [11:0] block_index,
  // result channel
  output logic        done,
  output logic [2:0]  status,
  output logic [11:0] allocated_block,
  output logic [11:0] free_blocks,
  output logic        full_flag,
  output logic        formatted_flag,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BW = feba_pkg::BW;
  localparam int EW = ($clog2(NUM_BLOCKS + 1) > feba_pkg::VBW) ?
                      $clog2(NUM_BLOCKS + 1) : feba_pkg::VBW;
  localparam int SW = $clog2(NUM_BLOCKS) + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_AEXE  = 4'b0010,
    S_FWALK = 4'b0100,
    S_FLINK = 4'b1000
  } state_t;

  state_t                    state, state_next;
  logic [feba_pkg::VBW-1:0]  volume_blocks;
  logic                      formatted, formatted_next;
  logic [BW-1:0]             free_head, free_head_next;
  logic [BW-1:0]             free_total, free_total_next;
  logic [BW-1:0]             bi, bi_next;
  logic [BW-1:0]             p, p_next;
  logic [BW-1:0]             prev, prev_next;
  logic [BW-1:0]             prev_len, prev_len_next;
  logic [SW-1:0]             steps, steps_next;
  logic                      done_next;
  logic [2:0]                status_next;
  logic [BW-1:0]             allocated_block_next;

  feba_pkg::hdr_req_t        req;
  feba_pkg::hdr_t            rdata;

  logic [EW-1:0]             vb_ext;
  logic [EW-1:0]             eff_blocks;
  logic [EW-1:0]             eff_m1;
  logic                      walk_on;
  logic [BW-1:0]             gap;
  logic                      accept;
  logic                      cfg_write;

  feba_hdr_store #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_hdr_store (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == feba_pkg::REG_VOLUME_BLOCKS) ?
                     {19'd0, volume_blocks} : 32'd0;

  // Clamp the volume size to the supported range
  always_comb begin
    vb_ext = EW'(volume_blocks);
    if (vb_ext < EW'(2)) begin
      eff_blocks = EW'(2);
    end else if (vb_ext > EW'(NUM_BLOCKS)) begin
      eff_blocks = EW'(NUM_BLOCKS);
    end else begin
      eff_blocks = vb_ext;
    end
  end
  assign eff_m1 = eff_blocks - EW'(1);

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Walk step: keep going while the listed block lies below the target
  assign walk_on = (p != '0) && (p < bi) && (steps < SW'(NUM_BLOCKS));
  assign gap     = bi - p;

  // Sequencer
  always_comb begin
    state_next           = state;
    formatted_next       = formatted;
    free_head_next       = free_head;
    free_total_next      = free_total;
    bi_next              = bi;
    p_next               = p;
    prev_next            = prev;
    prev_len_next        = prev_len;
    steps_next           = steps;
    done_next            = 1'b0;
    status_next          = status;
    allocated_block_next = allocated_block;
    req.we               = 1'b0;
    req.waddr            = '0;
    req.wdata            = '0;
    req.raddr            = free_head;

    case (state)
      S_IDLE: begin
        if (accept) begin
          bi_next              = block_index;
          done_next            = 1'b1;
          status_next          = feba_pkg::ST_OK;
          allocated_block_next = '0;
          case (opcode)
            feba_pkg::OP_FORMAT: begin
              if (formatted) begin
                status_next = feba_pkg::ST_ALREADY_FORMATTED;
              end else begin
                req.we          = 1'b1;
                req.waddr       = BW'(1);
                req.wdata.len   = eff_m1[BW-1:0];
                req.wdata.nxt   = '0;
                free_head_next  = BW'(1);
                free_total_next = eff_m1[BW-1:0];
                formatted_next  = 1'b1;
              end
            end
            feba_pkg::OP_ALLOC: begin
              if (!formatted) begin
                status_next = feba_pkg::ST_NOT_FORMATTED;
              end else if (free_total == '0 || free_head == '0) begin
                status_next = feba_pkg::ST_NO_SPACE;
              end else begin
                done_next  = 1'b0;
                state_next = S_AEXE;
              end
            end
            feba_pkg::OP_FREE: begin
              if (!formatted) begin
                status_next = feba_pkg::ST_NOT_FORMATTED;
              end else if (block_index == '0 ||
                           EW'(block_index) >= eff_blocks) begin
                status_next = feba_pkg::ST_RANGE;
              end else begin
                done_next     = 1'b0;
                p_next        = free_head;
                prev_next     = '0;
                prev_len_next = '0;
                steps_next    = '0;
                state_next    = S_FWALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Take the head block; shrink or unlink its extent
      S_AEXE: begin
        if (rdata.len <= BW'(1)) begin
          free_head_next = rdata.nxt;
        end else begin
          free_head_next = free_head + BW'(1);
          req.we         = 1'b1;
          req.waddr      = free_head + BW'(1);
          req.wdata.len  = rdata.len - BW'(1);
          req.wdata.nxt  = rdata.nxt;
        end
        free_total_next      = free_total - BW'(1);
        allocated_block_next = free_head;
        status_next          = feba_pkg::ST_OK;
        done_next            = 1'b1;
        state_next           = S_IDLE;
      end

      // One listed extent per cycle; read of the next header overlaps
      S_FWALK: begin
        req.raddr = rdata.nxt;
        if (walk_on) begin
          if (gap < rdata.len) begin
            status_next = feba_pkg::ST_ALREADY_FREE;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            prev_next     = p;
            prev_len_next = rdata.len;
            p_next        = rdata.nxt;
            steps_next    = steps + SW'(1);
          end
        end else if (p == bi) begin
          status_next = feba_pkg::ST_ALREADY_FREE;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          req.we        = 1'b1;
          req.waddr     = bi;
          req.wdata.len = BW'(1);
          req.wdata.nxt = p;
          if (prev == '0) begin
            free_head_next  = bi;
            free_total_next = free_total + BW'(1);
            status_next     = feba_pkg::ST_OK;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_FLINK;
          end
        end
      end

      // Point the predecessor at the new extent
      S_FLINK: begin
        req.we          = 1'b1;
        req.waddr       = prev;
        req.wdata.len   = prev_len;
        req.wdata.nxt   = bi;
        free_total_next = free_total + BW'(1);
        status_next     = feba_pkg::ST_OK;
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      formatted     <= 1'b0;
      free_head     <= '0;
      free_total    <= '0;
      volume_blocks <= feba_pkg::VOLUME_BLOCKS_RESET;
      done          <= 1'b0;
    end else begin
      state      <= state_next;
      formatted  <= formatted_next;
      free_head  <= free_head_next;
      free_total <= free_total_next;
      done       <= done_next;
      if (cfg_write && paddr[2] == feba_pkg::REG_VOLUME_BLOCKS) begin
        volume_blocks <= pwdata[feba_pkg::VBW-1:0];
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    bi              <= bi_next;
    p               <= p_next;
    prev            <= prev_next;
    prev_len        <= prev_len_next;
    steps           <= steps_next;
    status          <= status_next;
    allocated_block <= allocated_block_next;
  end

  // Counts and flags hold their post-operation values while done is high
  assign free_blocks    = free_total;
  assign full_flag      = (free_total == '0);
  assign formatted_flag = formatted;

  `FEBA_ASSERT_NEXT(a_accept_progress, accept, busy || done,
                    "accepted command neither running nor finished")
  `FEBA_ASSERT_NOW(a_done_idle, done, !busy,
                   "result word while sequencer still busy")
  `FEBA_ASSERT_NOW(a_fail_no_block, done && status != feba_pkg::ST_OK,
                   allocated_block == '0,
                   "failed command handed out a block")

endmodule

### rtl/feba_hdr_store.sv
// Extent header store: single write port, one registered read port.
// Depends on feba_pkg. Block numbers beyond the store read as zero.
`timescale 1ns / 1ps

module feba_hdr_store #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic              clk,
  input  feba_pkg::hdr_req_t req,
  output feba_pkg::hdr_t     rdata
);

  localparam int AW = $clog2(NUM_BLOCKS);

  feba_pkg::hdr_t mem [NUM_BLOCKS];
  feba_pkg::hdr_t rd_word;
  logic           rd_ok;

  logic [AW+feba_pkg::BW-1:0] waddr_ext;
  logic [AW+feba_pkg::BW-1:0] raddr_ext;
  logic                       wr_in_range;
  logic                       rd_in_range;

  // Map 12-bit block numbers onto the store depth
  assign waddr_ext   = {{AW{1'b0}}, req.waddr};
  assign raddr_ext   = {{AW{1'b0}}, req.raddr};
  assign wr_in_range = {20'd0, req.waddr} < 32'(NUM_BLOCKS);
  assign rd_in_range = {20'd0, req.raddr} < 32'(NUM_BLOCKS);

  // Write header, read header with registered data
  always_ff @(posedge clk) begin
    if (req.we && wr_in_range) begin
      mem[waddr_ext[AW-1:0]] <= req.wdata;
    end
    rd_word <= mem[raddr_ext[AW-1:0]];
    rd_ok   <= rd_in_range;
  end

  // Drop data for blocks outside the store
  assign rdata = rd_ok ? rd_word : '0;

endmodule

### tb/testbench.sv
// Self-checking testbench for the free extent block allocator.
// Depends on feba_pkg and the free_extent_block_allocator top level; predicts
// each untyped result word from its own copy of the free list and the volume size.
`timescale 1ns / 1ps

module testbench;

  localparam int NBLK = 4096;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [2:0] ADDR_VOLUME = 3'd0;
  localparam logic [2:0] ADDR_SPARE  = 3'd4;
  localparam int DIR_ROWS = 29;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 105;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] block;
    logic [11:0] free_cnt;
    logic        full;
    logic        fmt;
  } outcome_t;

  // One directed row: a register write or a command, with an optional typed result
  typedef struct packed {
    logic        cfg;
    logic [1:0]  op;
    logic [11:0] blk;
    logic [12:0] val;
    logic        typed;
    outcome_t    res;
  } drow_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [11:0] block_index;
  logic        done;
  logic [2:0]  status;
  logic [11:0] allocated_block;
  logic [11:0] free_blocks;
  logic        full_flag;
  logic        formatted_flag;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Allocator state as predicted
  logic [12:0] cfg_volume = feba_pkg::VOLUME_BLOCKS_RESET;
  bit          pm_formatted = 1'b0;
  int          pm_head = 0;
  int          pm_total = 0;
  logic [11:0] pm_len [NBLK] = '{default: '0};
  logic [11:0] pm_nxt [NBLK] = '{default: '0};

  outcome_t    outcome_q [$];
  logic [11:0] held_q [$];
  int          mismatches = 0;

  drow_t dir_tab [DIR_ROWS] = '{
    '{1'b0, feba_pkg::OP_ALLOC,  12'd0,    13'd0, 1'b1,
      '{feba_pkg::ST_NOT_FORMATTED, 12'd0, 12'd0, 1'b1, 1'b0}},
    '{1'b0, feba_pkg::OP_FREE,   12'd5,    13'd0, 1'b1,
      '{feba_pkg::ST_NOT_FORMATTED, 12'd0, 12'd0, 1'b1, 1'b0}},
    '{1'b0, OP_NONE,             12'hFFF,  13'd0, 1'b1,
      '{feba_pkg::ST_OK, 12'd0, 12'd0, 1'b1, 1'b0}},
    '{1'b1, OP_NONE,             12'd0,    13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd0,    13'd0, 1'b1,
      '{feba_pkg::ST_NOT_FORMATTED, 12'd0, 12'd0, 1'b1, 1'b0}},
    '{1'b1, OP_NONE,             12'd0,   13'd40, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FORMAT, 12'd0,    13'd0, 1'b1,
      '{feba_pkg::ST_OK, 12'd0, 12'd39, 1'b0, 1'b1}},
    '{1'b0, feba_pkg::OP_FORMAT, 12'hFFF,  13'd0, 1'b1,
      '{feba_pkg::ST_ALREADY_FORMATTED, 12'd0, 12'd39, 1'b0, 1'b1}},
    '{1'b0, feba_pkg::OP_ALLOC,  12'hFFF,  13'd0, 1'b1,
      '{feba_pkg::ST_OK, 12'd1, 12'd38, 1'b0, 1'b1}},
    '{1'b0, feba_pkg::OP_ALLOC,  12'd0,    13'd0, 1'b1,
      '{feba_pkg::ST_OK, 12'd2, 12'd37, 1'b0, 1'b1}},
    '{1'b0, feba_pkg::OP_FREE,   12'd0,    13'd0, 1'b1,
      '{feba_pkg::ST_RANGE, 12'd0, 12'd37, 1'b0, 1'b1}},
    '{1'b0, feba_pkg::OP_FREE,   12'd40,   13'd0, 1'b1,
      '{feba_pkg::ST_RANGE, 12'd0, 12'd37, 1'b0, 1'b1}},
    '{1'b0, feba_pkg::OP_FREE,   12'hFFF,  13'd0, 1'b1,
      '{feba_pkg::ST_RANGE, 12'd0, 12'd37, 1'b0, 1'b1}},
    '{1'b0, feba_pkg::OP_FREE,   12'd39,   13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd3,    13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd2,    13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd1,    13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd1,    13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_ALLOC,  12'd0,    13'd0, 1'b0, '0},
    '{1'b1, OP_NONE,             12'd0, 13'd4096, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'hFFF,  13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'hFFF,  13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd2048, 13'd0, 1'b0, '0},
    '{1'b1, OP_NONE,             12'd0,    13'd1, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd1,    13'd0, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd2,    13'd0, 1'b0, '0},
    '{1'b1, OP_NONE,             12'd0, 13'd8191, 1'b0, '0},
    '{1'b0, feba_pkg::OP_FREE,   12'd3000, 13'd0, 1'b0, '0},
    '{1'b0, OP_NONE,             12'd0,    13'd0, 1'b0, '0}
  };

  free_extent_block_allocator i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .block_index     (block_index),
    .done            (done),
    .status          (status),
    .allocated_block (allocated_block),
    .free_blocks     (free_blocks),
    .full_flag       (full_flag),
    .formatted_flag  (formatted_flag),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Volume size as the block sees it: clamp to 2..NBLK
  function automatic int eff_volume();
    int v;
    v = cfg_volume;
    if (v < 2) v = 2;
    if (v > NBLK) v = NBLK;
    return v;
  endfunction

  function automatic int hdr_len(input int b);
    return (b < NBLK) ? int'(pm_len[b]) : 0;
  endfunction

  function automatic int hdr_nxt(input int b);
    return (b < NBLK) ? int'(pm_nxt[b]) : 0;
  endfunction

  function automatic void put_hdr(input int b, input int len, input int nxt);
    if (b < NBLK) begin
      pm_len[b] = 12'(len);
      pm_nxt[b] = 12'(nxt);
    end
  endfunction

  // Count listed extents, bounded like the block's walk
  function automatic int chain_length();
    int p;
    int n;
    p = pm_head;
    n = 0;
    while (p != 0 && p < NBLK && n < NBLK) begin
      p = hdr_nxt(p);
      n++;
    end
    return n;
  endfunction

  // Apply one command to the predicted free list and return its result word
  function automatic outcome_t predict_outcome(input logic [1:0] op, input logic [11:0] blk);
    outcome_t o;
    int b;
    int p;
    int prev;
    int steps;
    int len;
    int nx;
    bit hit;
    o = '0;
    o.status = feba_pkg::ST_OK;
    b = blk;
    case (op)
      feba_pkg::OP_FORMAT: begin
        if (pm_formatted) begin
          o.status = feba_pkg::ST_ALREADY_FORMATTED;
        end else begin
          put_hdr(1, eff_volume() - 1, 0);
          pm_head = 1;
          pm_total = eff_volume() - 1;
          pm_formatted = 1'b1;
        end
      end
      feba_pkg::OP_ALLOC: begin
        if (!pm_formatted) begin
          o.status = feba_pkg::ST_NOT_FORMATTED;
        end else if (pm_total == 0 || pm_head == 0) begin
          o.status = feba_pkg::ST_NO_SPACE;
        end else begin
          p = pm_head;
          len = hdr_len(p);
          nx = hdr_nxt(p);
          // Unlink a one-block extent, else shrink it from the front
          if (len <= 1) begin
            pm_head = nx;
          end else begin
            pm_head = p + 1;
            put_hdr(p + 1, len - 1, nx);
          end
          pm_total--;
          o.block = 12'(p);
          held_q.push_back(12'(p));
        end
      end
      feba_pkg::OP_FREE: begin
        if (!pm_formatted) begin
          o.status = feba_pkg::ST_NOT_FORMATTED;
        end else if (b == 0 || b >= eff_volume()) begin
          o.status = feba_pkg::ST_RANGE;
        end else begin
          prev = 0;
          p = pm_head;
          steps = 0;
          hit = 1'b0;
          // Walk to the first extent at or above the block
          while (!hit && p != 0 && p < b && steps < NBLK) begin
            if (b - p < hdr_len(p)) begin
              hit = 1'b1;
            end else begin
              prev = p;
              p = hdr_nxt(p);
              steps++;
            end
          end
          if (hit || p == b) begin
            o.status = feba_pkg::ST_ALREADY_FREE;
          end else begin
            put_hdr(b, 1, p);
            if (prev == 0) pm_head = b;
            else put_hdr(prev, hdr_len(prev), b);
            pm_total++;
            for (int i = 0; i < held_q.size(); i++) begin
              if (held_q[i] == blk) begin
                held_q.delete(i);
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    o.free_cnt = 12'(pm_total);
    o.full = (pm_total == 0);
    o.fmt = pm_formatted;
    return o;
  endfunction

  // Drive one command word and hold it until the block takes it
  task automatic send_word(input logic [1:0] op, input logic [11:0] blk,
                           input bit typed, input outcome_t typed_res);
    outcome_t pred;
    @(negedge clk);
    start <= 1'b1;
    opcode <= op;
    block_index <= blk;
    do @(posedge clk); while (busy);
    pred = predict_outcome(op, blk);
    outcome_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_burst(input int n);
    @(negedge clk) start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Write a register once the block is idle, then read back the volume size
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk) start <= 1'b0;
    while (outcome_q.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == feba_pkg::REG_VOLUME_BLOCKS) cfg_volume = data[12:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_VOLUME;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {19'd0, cfg_volume}) begin
      $error("prdata: expected %0d, got %0d", cfg_volume, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Compare each result word against the oldest expectation
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (allocated_block !== want.block) begin
          $error("allocated_block: expected %0d, got %0d", want.block, allocated_block);
          mismatches++;
        end
        if (free_blocks !== want.free_cnt) begin
          $error("free_blocks: expected %0d, got %0d", want.free_cnt, free_blocks);
          mismatches++;
        end
        if (full_flag !== want.full) begin
          $error("full_flag: expected %0d, got %0d", want.full, full_flag);
          mismatches++;
        end
        if (formatted_flag !== want.fmt) begin
          $error("formatted_flag: expected %0d, got %0d", want.fmt, formatted_flag);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int phase_vol [PHASES];
    int alloc_pct;
    int held_end;
    int range_end;
    int r;
    logic [1:0] op;
    logic [11:0] blk;
    rst = 1'b1;
    start = 1'b0;
    opcode = feba_pkg::OP_FORMAT;
    block_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_VOLUME;
    pwdata = '0;
    phase_vol = '{4096, 2, 300, 8191, 0, 1, 4097, 2, 64, 4096};
    phase_vol[7] = $urandom_range(2, 4096);
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed rows: extremes, every opcode, list edge cases
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].cfg) begin
        reg_write(ADDR_VOLUME, ($urandom() & 32'hFFFF_E000) | dir_tab[i].val);
      end else begin
        if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 18));
        send_word(dir_tab[i].op, dir_tab[i].blk, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random phases: mostly allocate and free of held blocks, some noise
    for (int ph = 0; ph < PHASES; ph++) begin
      reg_write(ADDR_VOLUME, ($urandom() & 32'hFFFF_E000) | 32'(phase_vol[ph]));
      if (ph % 3 == 1) reg_write(ADDR_SPARE, $urandom());
      alloc_pct = (ph % 2 == 1) ? 60 : 30;
      held_end = alloc_pct + (96 - alloc_pct) / 2;
      range_end = held_end + (96 - held_end) / 2;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph != PHASES - 1 && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 18));
        blk = 12'($urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        if (chain_length() > 200 || r < alloc_pct) begin
          op = feba_pkg::OP_ALLOC;
        end else if (r < held_end && held_q.size() != 0) begin
          op = feba_pkg::OP_FREE;
          blk = held_q[$urandom_range(0, held_q.size() - 1)];
        end else if (r < range_end) begin
          op = feba_pkg::OP_FREE;
          blk = 12'($urandom_range(0, eff_volume()));
        end else if (r < 96) begin
          op = feba_pkg::OP_FREE;
        end else if (r < 98) begin
          op = feba_pkg::OP_FORMAT;
        end else begin
          op = OP_NONE;
        end
        send_word(op, blk, 1'b0, '0);
      end
    end

    // Drain outstanding results, then let the block settle
    @(negedge clk) start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("free_extent_block_allocator regression: pass");
    end else begin
      $display("free_extent_block_allocator regression: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(64'd20_000_000);
    $display("free_extent_block_allocator regression: fail");
    $finish;
  end

endmodule

### free_extent_block_allocator.f
+incdir+rtl
rtl/feba_pkg.sv
rtl/feba_hdr_store.sv
rtl/free_extent_block_allocator.sv
tb/testbench.sv
